[design/spr_pkg.sv]
// ----------------------------------------------------------------------------
// spr_pkg: shared types and constants of the sweep-and-prune box pair search
// Window geometry, entry layout, codes and small helper functions.
// ----------------------------------------------------------------------------
package spr_pkg;

	localparam int WINDOW_DEPTH = 32;
	localparam int ID_BITS      = 16;
	localparam int COORD_BITS   = 32;
	localparam int ADDR_BITS    = $clog2(WINDOW_DEPTH);
	localparam int CNT_BITS     = $clog2(WINDOW_DEPTH + 1);
	localparam int PAIRS_BITS   = 6;
	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [ADDR_BITS-1:0]         addr_t;
	typedef logic [CNT_BITS-1:0]          cnt_t;

	localparam coord_t MOST_NEG = {1'b1, {(COORD_BITS-1){1'b0}}};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_SWEEP_AXIS  = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SKIP_STATIC = 2'd1;

	// Sweep axis codes; the unused code selects x.
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// Result kinds and closing status codes.
	localparam logic KIND_PAIR  = 1'b0;
	localparam logic KIND_CLOSE = 1'b1;
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_OVERFLOW = 2'd1;
	localparam logic [1:0] STATUS_ORDER    = 2'd2;

	typedef struct packed {
		coord_t             min_x;
		coord_t             min_y;
		coord_t             min_z;
		coord_t             max_x;
		coord_t             max_y;
		coord_t             max_z;
		logic               is_static;
		logic [ID_BITS-1:0] ident;
	} spr_entry_t;

	localparam int ENTRY_BITS = $bits(spr_entry_t);

	function automatic coord_t axis_pick(logic [1:0] axis, coord_t x, coord_t y, coord_t z);
		coord_t r;
		case (axis)
			AXIS_Y:  r = y;
			AXIS_Z:  r = z;
			default: r = x;
		endcase
		return r;
	endfunction

	function automatic addr_t ptr_inc(addr_t p);
		addr_t r;
		if (p == addr_t'(WINDOW_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + addr_t'(1);
		end
		return r;
	endfunction

	function automatic logic overlap1(coord_t amin, coord_t amax, coord_t bmin, coord_t bmax);
		coord_t lo;
		coord_t hi;
		lo = (amin > bmin) ? amin : bmin;
		hi = (amax < bmax) ? amax : bmax;
		return lo <= hi;
	endfunction

endpackage

[design/spr_box_if.sv]
// ----------------------------------------------------------------------------
// spr_box_if: input box channel
// Valid/ready channel carrying one box per beat.
// ----------------------------------------------------------------------------
interface spr_box_if;
	logic                        valid;
	logic                        ready;
	logic signed [31:0]          min_x;
	logic signed [31:0]          min_y;
	logic signed [31:0]          min_z;
	logic signed [31:0]          max_x;
	logic signed [31:0]          max_y;
	logic signed [31:0]          max_z;
	logic                        is_static;
	logic [spr_pkg::ID_BITS-1:0] box_id;
	logic                        end_of_set;

	modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
		is_static, box_id, end_of_set, input ready);
	modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
		is_static, box_id, end_of_set, output ready);
endinterface

[design/spr_pair_if.sv]
// ----------------------------------------------------------------------------
// spr_pair_if: result channel
// Valid/ready channel carrying one pair or closing item per beat.
// ----------------------------------------------------------------------------
interface spr_pair_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [spr_pkg::ID_BITS-1:0] first_id;
	logic [spr_pkg::ID_BITS-1:0] second_id;
	logic [5:0]                  pair_count;
	logic [1:0]                  status;
	logic                        last_of_run;

	modport source (output valid, kind, first_id, second_id, pair_count, status,
		last_of_run, input ready);
	modport sink (input valid, kind, first_id, second_id, pair_count, status,
		last_of_run, output ready);
endinterface

[design/spr_cfg_if.sv]
// ----------------------------------------------------------------------------
// spr_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface spr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [spr_pkg::CFG_IDX_BITS-1:0]  index;
	logic [spr_pkg::CFG_DATA_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

[design/spr_ram.sv]
// ----------------------------------------------------------------------------
// spr_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered and holds
// while no read is issued.
// ----------------------------------------------------------------------------
module spr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

[design/sweep_and_prune_box_pairs.sv]
// ----------------------------------------------------------------------------
// sweep_and_prune_box_pairs: sweep-and-prune overlap search for 3D boxes
// Boxes sorted on the sweep axis come in; overlapping pairs and one closing
// item per box go out.
// ----------------------------------------------------------------------------
// The window of earlier boxes lives in a circular buffer in one RAM. For each
// accepted box the block walks the window oldest first, one entry per cycle
// unless a pair beat waits on a stalled output: an entry that no longer
// reaches the new box is dropped, a kept entry is written back packed behind
// the earlier kept ones, and a pair beat goes out for each overlap, save
// between two static boxes while static pairs are skipped. The new box is
// then appended and the closing beat sent. The entries are read through the
// one read port of the window RAM. One box is in work at a time; the next is
// accepted once the closing beat is in the output register.
// ----------------------------------------------------------------------------
module sweep_and_prune_box_pairs (
	input logic     clk,
	input logic     arst_n,
	spr_cfg_if.sink  cfg,
	spr_box_if.sink  box_in,
	spr_pair_if.source pair_out
);
	import spr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_EVAL  = 4'b0100,
		S_CLOSE = 4'b1000
	} state_t;

	state_t state_q;

	logic [1:0] sweep_axis_q;
	logic       skip_static_q;

	addr_t  head_q;
	cnt_t   count_q;
	addr_t  rptr_q;
	addr_t  wptr_q;
	cnt_t   remain_q;
	cnt_t   kept_q;
	logic [PAIRS_BITS-1:0] pairs_q;
	coord_t prev_min_q;
	coord_t nsweep_q;
	logic   order_err_q;
	logic   eos_q;
	spr_entry_t box_q;

	logic                  out_valid_q;
	logic                  out_kind_q;
	logic [ID_BITS-1:0]    out_first_q;
	logic [ID_BITS-1:0]    out_second_q;
	logic [PAIRS_BITS-1:0] out_count_q;
	logic [1:0]            out_status_q;
	logic                  out_last_q;

	spr_entry_t rd_entry;
	spr_entry_t wr_entry;
	logic       ram_we;
	addr_t      ram_waddr;
	logic       ram_re;
	addr_t      ram_raddr;

	logic   out_free;
	logic   in_fire;
	coord_t in_sweep;
	logic   keep;
	logic   hit;
	logic   proceed;
	logic   full_evict;
	logic   out_load;

	assign cfg.ready    = 1'b1;
	assign out_free     = !out_valid_q || pair_out.ready;
	assign box_in.ready = (state_q == S_IDLE);
	assign in_fire      = box_in.valid && box_in.ready;
	assign in_sweep     = axis_pick(sweep_axis_q, box_in.min_x, box_in.min_y, box_in.min_z);

	always_comb begin
		keep = axis_pick(sweep_axis_q, rd_entry.max_x, rd_entry.max_y, rd_entry.max_z)
			>= nsweep_q;
		hit = keep && !(skip_static_q && box_q.is_static && rd_entry.is_static)
			&& overlap1(rd_entry.min_x, rd_entry.max_x, box_q.min_x, box_q.max_x)
			&& overlap1(rd_entry.min_y, rd_entry.max_y, box_q.min_y, box_q.max_y)
			&& overlap1(rd_entry.min_z, rd_entry.max_z, box_q.min_z, box_q.max_z);
		proceed    = !hit || out_free;
		full_evict = (kept_q == cnt_t'(WINDOW_DEPTH));
		out_load   = ((state_q == S_EVAL) && proceed && hit)
			|| ((state_q == S_CLOSE) && out_free);
	end

	// Compaction writes never pass the read pointer, so no forwarding is needed.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wptr_q;
		wr_entry  = rd_entry;
		ram_re    = 1'b0;
		ram_raddr = rptr_q;
		case (state_q)
			S_START: begin
				ram_re = 1'b1;
			end
			S_EVAL: begin
				ram_we = proceed && keep;
				ram_re = proceed && (remain_q > cnt_t'(1));
			end
			S_CLOSE: begin
				ram_we   = out_free;
				wr_entry = box_q;
			end
			default: begin
			end
		endcase
	end

	spr_ram #(.WIDTH(ENTRY_BITS), .DEPTH(WINDOW_DEPTH)) u_window (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_axis_q  <= '0;
			skip_static_q <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_SWEEP_AXIS:  sweep_axis_q  <= cfg.data;
				REG_SKIP_STATIC: skip_static_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			box_q.min_x     <= box_in.min_x;
			box_q.min_y     <= box_in.min_y;
			box_q.min_z     <= box_in.min_z;
			box_q.max_x     <= box_in.max_x;
			box_q.max_y     <= box_in.max_y;
			box_q.max_z     <= box_in.max_z;
			box_q.is_static <= box_in.is_static;
			box_q.ident     <= box_in.box_id;
			nsweep_q        <= in_sweep;
			eos_q           <= box_in.end_of_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			rptr_q       <= '0;
			wptr_q       <= '0;
			remain_q     <= '0;
			kept_q       <= '0;
			pairs_q      <= '0;
			prev_min_q   <= MOST_NEG;
			order_err_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_kind_q   <= KIND_PAIR;
			out_first_q  <= '0;
			out_second_q <= '0;
			out_count_q  <= '0;
			out_status_q <= STATUS_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && pair_out.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						order_err_q <= (in_sweep < prev_min_q);
						prev_min_q  <= in_sweep;
						rptr_q      <= head_q;
						wptr_q      <= head_q;
						remain_q    <= count_q;
						kept_q      <= '0;
						pairs_q     <= '0;
						state_q     <= (count_q == '0) ? S_CLOSE : S_START;
					end
				end
				S_START: begin
					rptr_q  <= ptr_inc(rptr_q);
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (proceed) begin
						if (keep) begin
							wptr_q <= ptr_inc(wptr_q);
							kept_q <= kept_q + cnt_t'(1);
						end
						if (hit) begin
							out_kind_q   <= KIND_PAIR;
							out_first_q  <= rd_entry.ident;
							out_second_q <= box_q.ident;
							out_count_q  <= '0;
							out_status_q <= STATUS_OK;
							out_last_q   <= 1'b0;
							pairs_q      <= pairs_q + PAIRS_BITS'(1);
						end
						remain_q <= remain_q - cnt_t'(1);
						if (remain_q > cnt_t'(1)) begin
							rptr_q <= ptr_inc(rptr_q);
						end else begin
							state_q <= S_CLOSE;
						end
					end
				end
				S_CLOSE: begin
					if (out_free) begin
						out_kind_q   <= KIND_CLOSE;
						out_first_q  <= '0;
						out_second_q <= box_q.ident;
						out_count_q  <= pairs_q;
						out_last_q   <= 1'b1;
						if (order_err_q) begin
							out_status_q <= STATUS_ORDER;
						end else if (full_evict) begin
							out_status_q <= STATUS_OVERFLOW;
						end else begin
							out_status_q <= STATUS_OK;
						end
						// A full window wraps the write pointer onto the oldest slot.
						if (full_evict) begin
							head_q <= ptr_inc(head_q);
						end
						if (eos_q) begin
							count_q    <= '0;
							prev_min_q <= MOST_NEG;
						end else if (full_evict) begin
							count_q <= cnt_t'(WINDOW_DEPTH);
						end else begin
							count_q <= kept_q + cnt_t'(1);
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign pair_out.valid       = out_valid_q;
	assign pair_out.kind        = out_kind_q;
	assign pair_out.first_id    = out_first_q;
	assign pair_out.second_id   = out_second_q;
	assign pair_out.pair_count  = out_count_q;
	assign pair_out.status      = out_status_q;
	assign pair_out.last_of_run = out_last_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(WINDOW_DEPTH))
		else $error("window count above depth");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> kept_q <= count_q)
		else $error("more entries kept than were in the window");

	a_close_last: assert property (@(posedge clk) disable iff (!arst_n)
		pair_out.valid |-> (pair_out.kind == KIND_CLOSE) == pair_out.last_of_run)
		else $error("closing beat and last flag disagree");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("state register not one-hot");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q != S_IDLE)
		else $error("box accepted but no work started");
`endif
endmodule

[verif/sweep_and_prune_box_pairs_tb.sv]
// ----------------------------------------------------------------------------
// sweep_and_prune_box_pairs_tb: self-checking bench of the box pair search
// Sorted box sets, noise and broken sets are fed through the box channel under
// random gaps and output stalls. A window model in the bench predicts every
// pair and closing beat, which the monitor compares in order.
// ----------------------------------------------------------------------------
module sweep_and_prune_box_pairs_tb;
	import spr_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		spr_entry_t e;
		logic       eos;
	} box_item_t;

	typedef struct packed {
		logic               kind;
		logic [ID_BITS-1:0] first_id;
		logic [ID_BITS-1:0] second_id;
		logic [5:0]         pair_count;
		logic [1:0]         status;
		logic               last_of_run;
	} pair_beat_t;

	localparam coord_t MOST_POS = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam int DRAIN_CYCLES = 40;
	localparam int IDLE_LIMIT   = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	spr_cfg_if  cfg();
	spr_box_if  box_in();
	spr_pair_if pair_out();

	sweep_and_prune_box_pairs u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.box_in   (box_in),
		.pair_out (pair_out)
	);

	always #1 clk = ~clk;

	box_item_t  pending_boxes[$];
	pair_beat_t expected_beats[$];
	box_item_t  cur_box;
	bit         box_offered = 0;
	int         box_gap = 0;
	int         pair_stall = 0;
	int         holdoff_left = 0;
	bit         no_idle = 0;
	int         mismatches = 0;
	int         idle_cycles = 0;

	// Window model state.
	spr_entry_t win[WINDOW_DEPTH];
	int         win_cnt = 0;
	coord_t     prev_sweep_min = MOST_NEG;
	logic [1:0] cur_axis = 2'd0;
	logic       cur_skip = 1'b0;

	function automatic void bounds(spr_entry_t e, output coord_t lo[3], output coord_t hi[3]);
		lo[0] = e.min_x; lo[1] = e.min_y; lo[2] = e.min_z;
		hi[0] = e.max_x; hi[1] = e.max_y; hi[2] = e.max_z;
	endfunction

	function automatic void predict_box(box_item_t b);
		coord_t     nlo[3], nhi[3], wlo[3], whi[3];
		coord_t     ns, lo, hi;
		int         sel, kept, pairs;
		logic [1:0] st;
		bit         hit;
		pair_beat_t beat;
		sel = (cur_axis == AXIS_Y) ? 1 : (cur_axis == AXIS_Z) ? 2 : 0;
		bounds(b.e, nlo, nhi);
		ns = nlo[sel];
		st = STATUS_OK;
		if (ns < prev_sweep_min) st = STATUS_ORDER;
		prev_sweep_min = ns;
		kept = 0;
		for (int i = 0; i < win_cnt; i++) begin
			bounds(win[i], wlo, whi);
			if (whi[sel] < ns) continue;
			win[kept] = win[i];
			kept++;
		end
		win_cnt = kept;
		pairs = 0;
		for (int i = 0; i < win_cnt; i++) begin
			if (cur_skip && b.e.is_static && win[i].is_static) continue;
			bounds(win[i], wlo, whi);
			hit = 1;
			for (int a = 0; a < 3; a++) begin
				lo = (wlo[a] > nlo[a]) ? wlo[a] : nlo[a];
				hi = (whi[a] < nhi[a]) ? whi[a] : nhi[a];
				if (lo > hi) hit = 0;
			end
			if (!hit) continue;
			beat = '{KIND_PAIR, win[i].ident, b.e.ident, 6'd0, STATUS_OK, 1'b0};
			expected_beats.push_back(beat);
			pairs++;
		end
		if (win_cnt >= WINDOW_DEPTH) begin
			for (int i = 1; i < WINDOW_DEPTH; i++) win[i-1] = win[i];
			win_cnt = WINDOW_DEPTH - 1;
			if (st == STATUS_OK) st = STATUS_OVERFLOW;
		end
		win[win_cnt] = b.e;
		win_cnt++;
		beat = '{KIND_CLOSE, '0, b.e.ident, 6'(pairs), st, 1'b1};
		expected_beats.push_back(beat);
		if (b.eos) begin
			win_cnt = 0;
			prev_sweep_min = MOST_NEG;
		end
	endfunction

	// Box driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (box_in.valid && box_in.ready) begin
				predict_box(cur_box);
				box_offered = 0;
			end
			if (!box_offered) begin
				if (box_gap > 0) begin
					box_gap--;
				end else if (pending_boxes.size() > 0) begin
					cur_box = pending_boxes.pop_front();
					box_in.min_x      <= cur_box.e.min_x;
					box_in.min_y      <= cur_box.e.min_y;
					box_in.min_z      <= cur_box.e.min_z;
					box_in.max_x      <= cur_box.e.max_x;
					box_in.max_y      <= cur_box.e.max_y;
					box_in.max_z      <= cur_box.e.max_z;
					box_in.is_static  <= cur_box.e.is_static;
					box_in.box_id     <= cur_box.e.ident;
					box_in.end_of_set <= cur_box.eos;
					box_offered = 1;
					box_gap = no_idle ? 0 : $urandom_range(0, 11);
				end
			end
			box_in.valid <= box_offered;
		end
	end

	// Result monitor.
	always @(posedge clk) begin
		pair_beat_t got, want;
		if (arst_n) begin
			if (pair_out.valid && pair_out.ready) begin
				got = '{pair_out.kind, pair_out.first_id, pair_out.second_id,
					pair_out.pair_count, pair_out.status, pair_out.last_of_run};
				if (expected_beats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected beat: %p", got);
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10)
							$display("beat mismatch: expected %p, got %p", want, got);
					end
				end
				pair_stall = no_idle ? 0 : $urandom_range(0, 11);
			end else if (pair_stall > 0) begin
				pair_stall--;
			end
			if (holdoff_left > 0) holdoff_left--;
			pair_out.ready <= (pair_stall == 0) && (holdoff_left == 0);
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((box_in.valid && box_in.ready) || (pair_out.valid && pair_out.ready) ||
				(cfg.valid && cfg.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("sweep_and_prune_box_pairs_tb: done, errors");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == REG_SWEEP_AXIS) cur_axis = value;
		else if (idx == REG_SKIP_STATIC) cur_skip = value[0];
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_boxes.size() > 0 || box_offered || expected_beats.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic box_item_t make_box(coord_t lo[3], coord_t hi[3], logic stat,
			logic [ID_BITS-1:0] id, logic eos);
		box_item_t b;
		b.e.min_x = lo[0]; b.e.min_y = lo[1]; b.e.min_z = lo[2];
		b.e.max_x = hi[0]; b.e.max_y = hi[1]; b.e.max_z = hi[2];
		b.e.is_static = stat;
		b.e.ident = id;
		b.eos = eos;
		return b;
	endfunction

	function automatic box_item_t noise_box();
		coord_t lo[3], hi[3];
		for (int a = 0; a < 3; a++) begin
			lo[a] = $urandom;
			hi[a] = $urandom;
		end
		return make_box(lo, hi, 1'($urandom_range(0, 1)), ID_BITS'($urandom),
			$urandom_range(0, 9) == 0);
	endfunction

	// Sets mostly sorted on the sweep axis (others are noise boxes), with small
	// crowded boxes so that pairs are common; long reach on the sweep axis fills the window.
	task automatic add_sets(int n, bit long_reach);
		coord_t lo[3], hi[3];
		coord_t pos;
		int sel, len, made;
		bit sorted;
		sel = (cur_axis == AXIS_Y) ? 1 : (cur_axis == AXIS_Z) ? 2 : 0;
		made = 0;
		while (made < n) begin
			len = long_reach ? 40 : $urandom_range(1, 12);
			sorted = long_reach || ($urandom_range(0, 9) < 7);
			pos = coord_t'($urandom_range(0, 4000)) <<< 10;
			pos = pos - (coord_t'(2000) <<< 10);
			for (int k = 0; k < len; k++) begin
				if (!sorted) begin
					pending_boxes.push_back(noise_box());
				end else begin
					for (int a = 0; a < 3; a++) begin
						lo[a] = (coord_t'($urandom_range(0, 8)) - 4) <<< 16;
						hi[a] = lo[a] + (coord_t'($urandom_range(0, 3)) <<< 16);
					end
					if ($urandom_range(0, 9) == 0) pos = pos - (coord_t'(1) <<< 16);
					else pos = pos + (coord_t'($urandom_range(0, 3)) <<< 14);
					lo[sel] = pos;
					hi[sel] = pos + (long_reach ? (coord_t'(1) <<< 28)
						: (coord_t'($urandom_range(0, 4)) <<< 15));
					if ($urandom_range(0, 19) == 0) hi[0] = lo[0] - 1;
					pending_boxes.push_back(make_box(lo, hi, 1'($urandom_range(0, 1)),
						ID_BITS'($urandom), k == len - 1));
				end
			end
			made += len;
		end
	endtask

	initial begin
		coord_t lo[3], hi[3];
		box_in.valid = 1'b0;
		box_in.min_x = '0; box_in.min_y = '0; box_in.min_z = '0;
		box_in.max_x = '0; box_in.max_y = '0; box_in.max_z = '0;
		box_in.is_static = 1'b0; box_in.box_id = '0; box_in.end_of_set = 1'b0;
		cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
		pair_out.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extreme bounds, inclusive touch, degenerate box, out of order.
		write_reg(REG_SWEEP_AXIS, 2'd0);
		write_reg(REG_SKIP_STATIC, 2'd0);
		lo = '{MOST_NEG, MOST_NEG, MOST_NEG}; hi = '{MOST_POS, MOST_POS, MOST_POS};
		pending_boxes.push_back(make_box(lo, hi, 1'b0, 16'h0000, 1'b0));
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'hFFFF, 1'b0));
		lo = '{MOST_POS, MOST_POS, MOST_POS};
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'h0001, 1'b0));
		lo = '{MOST_POS, 32'sd5, 32'sd5}; hi = '{MOST_POS, -32'sd5, -32'sd5};
		pending_boxes.push_back(make_box(lo, hi, 1'b0, 16'h0002, 1'b0));
		lo = '{MOST_NEG, 32'sd0, 32'sd0}; hi = '{32'sd0, 32'sd0, 32'sd0};
		pending_boxes.push_back(make_box(lo, hi, 1'b0, 16'h0003, 1'b1));
		// A box that is alone in its set.
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'h8000, 1'b1));
		wait_idle();

		// Directed: static pairs skipped, unused axis code acting as x.
		write_reg(REG_SWEEP_AXIS, 2'd3);
		write_reg(REG_SKIP_STATIC, 2'd1);
		lo = '{32'sd0, 32'sd0, 32'sd0}; hi = '{32'sd100, 32'sd100, 32'sd100};
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'h0010, 1'b0));
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'h0011, 1'b0));
		pending_boxes.push_back(make_box(lo, hi, 1'b0, 16'h0012, 1'b0));
		lo = '{32'sd100, -32'sd50, 32'sd100}; hi = '{32'sd200, 32'sd0, 32'sd100};
		pending_boxes.push_back(make_box(lo, hi, 1'b0, 16'h0013, 1'b0));
		lo = '{32'sd201, 32'sd0, 32'sd0};
		pending_boxes.push_back(make_box(lo, hi, 1'b1, 16'h0014, 1'b1));
		wait_idle();

		// Random, with one long output hold-off while boxes keep coming.
		write_reg(REG_SWEEP_AXIS, 2'd1);
		write_reg(REG_SKIP_STATIC, 2'd0);
		add_sets(15, 0);
		holdoff_left = 400;
		wait_idle();

		write_reg(REG_SWEEP_AXIS, 2'd2);
		write_reg(REG_SKIP_STATIC, 2'd1);
		no_idle = 1;
		add_sets(15, 0);
		wait_idle();
		no_idle = 0;

		// A window that overflows.
		write_reg(REG_SWEEP_AXIS, 2'd0);
		add_sets(40, 1);
		wait_idle();

		write_reg(REG_SWEEP_AXIS, 2'd3);
		write_reg(REG_SKIP_STATIC, 2'd0);
		add_sets(15, 0);
		wait_idle();

		write_reg(REG_SWEEP_AXIS, 2'd2);
		add_sets(15, 0);
		wait_idle();

		if (mismatches == 0) begin
			$display("sweep_and_prune_box_pairs_tb: done, clean");
		end else begin
			$display("sweep_and_prune_box_pairs_tb: done, errors");
		end
		$finish;
	end

endmodule

[files.f]
design/spr_pkg.sv
design/spr_box_if.sv
design/spr_pair_if.sv
design/spr_cfg_if.sv
design/spr_ram.sv
design/sweep_and_prune_box_pairs.sv
verif/sweep_and_prune_box_pairs_tb.sv
